### sv/hmbd_pkg.sv
// ----------------------------------------------------------------------------
// hmbd_pkg
// Shared types and constants of the handheld memory bus decoder: request and
// response payloads, target and violation codes, memory map bounds, ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hmbd_pkg;

  // store geometry
  localparam int WORK_RAM_BYTES = 8192;
  localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
  localparam int IO_BYTES       = 256;
  localparam int IO_AW          = $clog2(IO_BYTES);

  // i/o page ports
  localparam logic [IO_AW-1:0] DIVIDER_SLOT   = IO_AW'(4);
  localparam logic [IO_AW-1:0] PORT_JOYPAD    = IO_AW'(8'h00);
  localparam logic [IO_AW-1:0] PORT_READ_ONLY = IO_AW'(8'h44);
  localparam logic [IO_AW-1:0] PORT_DMA       = IO_AW'(8'h46);

  // joypad select merge masks
  localparam logic [7:0] JOYPAD_KEEP_MASK = 8'hCF;
  localparam logic [7:0] JOYPAD_SEL_MASK  = 8'h30;

  // memory map bounds
  localparam logic [15:0] ADDR_VRAM_BASE   = 16'h8000;
  localparam logic [15:0] ADDR_CART2_BASE  = 16'hA000;
  localparam logic [15:0] ADDR_WRAM_BASE   = 16'hC000;
  localparam logic [15:0] ADDR_OAM_BASE    = 16'hFE00;
  localparam logic [15:0] ADDR_UNMAP_BASE  = 16'hFEA0;
  localparam logic [15:0] ADDR_IO_BASE     = 16'hFF00;

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [2:0] {
    TGT_INTERNAL = 3'd0,
    TGT_CART     = 3'd1,
    TGT_VRAM     = 3'd2,
    TGT_OAM      = 3'd3,
    TGT_UNMAPPED = 3'd4
  } target_t;

  typedef enum logic [1:0] {
    VIOL_NONE       = 2'd0,
    VIOL_READ_ONLY  = 2'd1,
    VIOL_WRITE_ONLY = 2'd2,
    VIOL_UNMAPPED   = 2'd3
  } viol_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    target_t     target;
    logic [15:0] forward_address;
    logic        forward_write;
    logic [7:0]  forward_data;
    logic        joypad_update;
    logic        dma_start;
    logic [15:0] dma_source;
    viol_t       violation;
  } rsp_t;

endpackage

`default_nettype wire

### sv/handheld_memory_bus_decoder_top.sv
// ----------------------------------------------------------------------------
// handheld_memory_bus_decoder_top
// Decodes byte reads and writes against the handheld memory map; work RAM and
// the i/o page live in two synchronous RAMs updated by read-modify-write.
// ----------------------------------------------------------------------------
// path: a request is read from the RAMs as it enters the decode stage; the
//   decode stage then writes back to the RAMs and fills the output register
// throughput: one request per cycle while not stalled; the single write-back stage
//   and a one entry bypass per RAM cover a read of the entry written just before
// reset: synchronous, active low; afterwards a clearing pass zeroes both RAMs,
//   one work RAM entry per cycle, with in_ready held low
`timescale 1ns / 1ps
`default_nettype none

module handheld_memory_bus_decoder_top import hmbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);

  // clearing pass
  logic               clr_active_r, clr_active_nxt;
  logic [WRAM_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // decode stage and output register
  logic s1_v_r, s1_v_nxt;
  req_t s1_req_r;
  logic out_v_r, out_v_nxt;
  rsp_t out_rsp_r;

  // bypass of the last write into each RAM
  logic               wbyp_v_r;
  logic [WRAM_AW-1:0] wbyp_idx_r;
  logic [7:0]         wbyp_data_r;
  logic               iobyp_v_r;
  logic [IO_AW-1:0]   iobyp_idx_r;
  logic [7:0]         iobyp_data_r;

  logic accept, s1_adv;
  req_t rd_req;

  // RAM ports
  logic               wram_we;
  logic [WRAM_AW-1:0] wram_waddr, wram_raddr;
  logic [7:0]         wram_wdata, wram_q;
  logic               io_we;
  logic [IO_AW-1:0]   io_waddr, io_raddr;
  logic [7:0]         io_wdata, io_q;

  // decode results
  logic               dec_wram_wr, dec_io_wr;
  logic [7:0]         dec_wram_wd, dec_io_wd;
  logic [7:0]         wram_cur, io_cur;
  logic [WRAM_AW-1:0] s1_widx;
  logic [IO_AW-1:0]   s1_port;
  rsp_t               dec_rsp;

  // handshake
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !clr_active_r && (!s1_v_r || s1_adv);
  assign accept   = in_valid && in_ready;

  assign out_valid = out_v_r;
  assign out_rsp   = out_rsp_r;

  // read address: new request, or re-read of the one held in the decode stage
  assign rd_req     = accept ? in_req : s1_req_r;
  assign wram_raddr = rd_req.address[WRAM_AW-1:0];
  assign io_raddr   = rd_req.address[IO_AW-1:0];

  assign s1_widx = s1_req_r.address[WRAM_AW-1:0];
  assign s1_port = s1_req_r.address[IO_AW-1:0];

  // current entry values with bypass of the write in the cycle before
  assign wram_cur = (wbyp_v_r && wbyp_idx_r == s1_widx) ? wbyp_data_r : wram_q;
  assign io_cur   = (iobyp_v_r && iobyp_idx_r == s1_port) ? iobyp_data_r : io_q;

  // memory map decode
  always_comb begin
    logic [15:0] a;
    logic        wr;
    logic [7:0]  v;
    a           = s1_req_r.address;
    wr          = (s1_req_r.kind == KIND_WRITE);
    v           = s1_req_r.write_data;
    dec_rsp     = '0;
    dec_wram_wr = 1'b0;
    dec_wram_wd = v;
    dec_io_wr   = 1'b0;
    dec_io_wd   = v;
    if (a < ADDR_VRAM_BASE || (a >= ADDR_CART2_BASE && a < ADDR_WRAM_BASE)) begin
      dec_rsp.target = TGT_CART;
    end else if (a < ADDR_CART2_BASE) begin
      dec_rsp.target = TGT_VRAM;
    end else if (a < ADDR_OAM_BASE) begin
      // work ram and its echo share the low index bits
      dec_rsp.target = TGT_INTERNAL;
      if (wr) begin
        dec_wram_wr = 1'b1;
      end else begin
        dec_rsp.read_data = wram_cur;
      end
    end else if (a < ADDR_UNMAP_BASE) begin
      dec_rsp.target = TGT_OAM;
    end else if (a < ADDR_IO_BASE) begin
      dec_rsp.target    = TGT_UNMAPPED;
      dec_rsp.violation = VIOL_UNMAPPED;
    end else begin
      dec_rsp.target = TGT_INTERNAL;
      if (wr) begin
        if (s1_port == PORT_JOYPAD) begin
          dec_io_wr             = 1'b1;
          dec_io_wd             = (io_cur & JOYPAD_KEEP_MASK) | (v & JOYPAD_SEL_MASK);
          dec_rsp.joypad_update = 1'b1;
        end else if (s1_port == PORT_READ_ONLY) begin
          dec_rsp.violation = VIOL_READ_ONLY;
        end else if (s1_port == DIVIDER_SLOT) begin
          dec_io_wr = 1'b1;
          dec_io_wd = 8'h00;
        end else begin
          dec_io_wr = 1'b1;
          if (s1_port == PORT_DMA) begin
            dec_rsp.dma_start  = 1'b1;
            dec_rsp.dma_source = {v, 8'h00};
          end
        end
      end else begin
        if (s1_port == PORT_DMA) begin
          dec_rsp.violation = VIOL_WRITE_ONLY;
        end
        dec_rsp.read_data = io_cur;
      end
    end
    // forwarded accesses
    if (dec_rsp.target == TGT_CART || dec_rsp.target == TGT_VRAM ||
        dec_rsp.target == TGT_OAM) begin
      dec_rsp.forward_address = a;
      if (wr) begin
        dec_rsp.forward_write = 1'b1;
        dec_rsp.forward_data  = v;
      end
    end
  end

  // RAM write ports: clearing pass or write-back of the decode stage
  always_comb begin
    if (clr_active_r) begin
      wram_we    = 1'b1;
      wram_waddr = clr_cnt_r;
      wram_wdata = 8'h00;
      io_we      = 1'b1;
      io_waddr   = clr_cnt_r[IO_AW-1:0];
      io_wdata   = 8'h00;
    end else begin
      wram_we    = s1_adv && dec_wram_wr;
      wram_waddr = s1_widx;
      wram_wdata = dec_wram_wd;
      io_we      = s1_adv && dec_io_wr;
      io_waddr   = s1_port;
      io_wdata   = dec_io_wd;
    end
  end

  // next state of control registers
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (clr_active_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == WRAM_AW'(WORK_RAM_BYTES - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
    s1_v_nxt  = accept || (s1_v_r && !s1_adv);
    out_v_nxt = s1_adv || (out_v_r && !out_ready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      wbyp_v_r     <= 1'b0;
      iobyp_v_r    <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      s1_v_r       <= s1_v_nxt;
      out_v_r      <= out_v_nxt;
      wbyp_v_r     <= !clr_active_r && wram_we;
      iobyp_v_r    <= !clr_active_r && io_we;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= in_req;
    end
    if (s1_adv) begin
      out_rsp_r <= dec_rsp;
    end
    wbyp_idx_r   <= wram_waddr;
    wbyp_data_r  <= wram_wdata;
    iobyp_idx_r  <= io_waddr;
    iobyp_data_r <= io_wdata;
  end

  // work ram store
  hmbd_ram #(
    .WIDTH (8),
    .DEPTH (WORK_RAM_BYTES)
  ) u_wram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .raddr (wram_raddr),
    .rdata (wram_q)
  );

  // i/o page store
  hmbd_ram #(
    .WIDTH (8),
    .DEPTH (IO_BYTES)
  ) u_io (
    .clk   (clk),
    .we    (io_we),
    .waddr (io_waddr),
    .wdata (io_wdata),
    .raddr (io_raddr),
    .rdata (io_q)
  );

endmodule

`default_nettype wire

### sv/hmbd_ram.sv
// ----------------------------------------------------------------------------
// hmbd_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/hmbd_checker.sv
// ----------------------------------------------------------------------------
// hmbd_checker
// Port-level checks of the handheld memory bus decoder, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmbd_checker import hmbd_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_rsp
);

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  // no request taken as the clearing pass that follows reset begins
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken before store clear");

  // a dma start is an internal port write with a page-aligned source
  a_dma_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.dma_start |->
      out_rsp.target == TGT_INTERNAL && out_rsp.violation == VIOL_NONE &&
      out_rsp.dma_source[7:0] == 8'h00 && !out_rsp.forward_write)
    else $error("malformed dma start");

  // unmapped accesses read zero and are flagged
  a_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.target == TGT_UNMAPPED |->
      out_rsp.violation == VIOL_UNMAPPED && out_rsp.read_data == 8'h00 &&
      out_rsp.forward_address == 16'h0000)
    else $error("unmapped access not flagged");

  // only forwarded accesses carry a forward write
  a_fwd_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.forward_write |->
      out_rsp.target == TGT_CART || out_rsp.target == TGT_VRAM ||
      out_rsp.target == TGT_OAM)
    else $error("forward write on internal access");

endmodule

bind handheld_memory_bus_decoder_top hmbd_checker u_hmbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the handheld memory bus decoder. A short table of
// directed requests covers the map edges and the special i/o ports. Weighted
// random requests follow. Each response is checked field by field against a
// table row or a behavioral decoder holding copies of work RAM and i/o page.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hmbd_pkg::*;

  localparam int          RANDOM_REQUESTS = 850;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          BACKPRESSURE_AT = 250;
  localparam int          BACKPRESSURE_LEN = 300;
  localparam logic [15:0] ECHO_BASE       = 16'hE000;
  localparam logic [15:0] ECHO_SHIFT      = 16'h2000;

  typedef struct packed {
    req_t req;
    logic known;
    rsp_t rsp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_req;
  logic out_valid;
  logic out_ready;
  rsp_t out_rsp;

  // decoder image of the internal stores
  logic [7:0] wram_image [WORK_RAM_BYTES];
  logic [7:0] io_image [IO_BYTES];

  rsp_t      pending_responses[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        responses_seen = 0;
  int        cycle_count = 0;

  always #2 clk = ~clk;

  handheld_memory_bus_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  // behavioral decode of one access, updating the store images
  function automatic rsp_t decode_access(input req_t r);
    rsp_t        o;
    logic [15:0] a;
    logic [15:0] off;
    logic [7:0]  port;
    o = '0;
    a = r.address;
    if (a >= ECHO_BASE && a < ADDR_OAM_BASE) a = a - ECHO_SHIFT;
    if (a < ADDR_VRAM_BASE || (a >= ADDR_CART2_BASE && a < ADDR_WRAM_BASE)) begin
      o.target = TGT_CART;
    end else if (a < ADDR_CART2_BASE) begin
      o.target = TGT_VRAM;
    end else if (a < ECHO_BASE) begin
      o.target = TGT_INTERNAL;
      off = a - ADDR_WRAM_BASE;
      if (r.kind == KIND_WRITE) wram_image[off[WRAM_AW-1:0]] = r.write_data;
      else o.read_data = wram_image[off[WRAM_AW-1:0]];
    end else if (a >= ADDR_OAM_BASE && a < ADDR_UNMAP_BASE) begin
      o.target = TGT_OAM;
    end else if (a < ADDR_IO_BASE) begin
      o.target = TGT_UNMAPPED;
      o.violation = VIOL_UNMAPPED;
    end else begin
      o.target = TGT_INTERNAL;
      port = a[7:0];
      if (r.kind == KIND_WRITE) begin
        if (port == PORT_JOYPAD) begin
          io_image[port] = (io_image[port] & JOYPAD_KEEP_MASK) | (r.write_data & JOYPAD_SEL_MASK);
          o.joypad_update = 1'b1;
        end else if (port == PORT_READ_ONLY) begin
          o.violation = VIOL_READ_ONLY;
        end else if (port == DIVIDER_SLOT) begin
          // divider clear wins over everything else on this slot
          io_image[port] = 8'h00;
        end else begin
          io_image[port] = r.write_data;
          if (port == PORT_DMA) begin
            o.dma_start  = 1'b1;
            o.dma_source = {r.write_data, 8'h00};
          end
        end
      end else begin
        if (port == PORT_DMA) o.violation = VIOL_WRITE_ONLY;
        o.read_data = io_image[port];
      end
    end
    // forwarded targets carry the original address
    if (o.target == TGT_CART || o.target == TGT_VRAM || o.target == TGT_OAM) begin
      o.forward_address = r.address;
      if (r.kind == KIND_WRITE) begin
        o.forward_write = 1'b1;
        o.forward_data  = r.write_data;
      end
    end
    return o;
  endfunction

  function automatic rsp_t rsp_of(input logic [7:0] rd, input target_t tgt,
                                  input logic [15:0] faddr, input logic fwr,
                                  input logic [7:0] fdata, input logic joy,
                                  input logic dma, input logic [15:0] src,
                                  input viol_t viol);
    return '{rd, tgt, faddr, fwr, fdata, joy, dma, src, viol};
  endfunction

  function automatic stim_row_t access_row(input logic kind, input logic [15:0] addr,
                                           input logic [7:0] data);
    return '{'{kind, addr, data}, 1'b0, '0};
  endfunction

  function automatic stim_row_t known_row(input logic kind, input logic [15:0] addr,
                                          input logic [7:0] data, input rsp_t rsp);
    return '{'{kind, addr, data}, 1'b1, rsp};
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_byte();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // weighted toward the internal stores, with reuse of a few work RAM bytes
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    logic [15:0] off;
    logic [7:0]  port;
    pick         = $urandom_range(0, 99);
    r.kind       = 1'($urandom_range(0, 1));
    r.write_data = random_byte();
    if (pick < 30) begin
      if ($urandom_range(0, 1)) begin
        off = 16'($urandom_range(0, 15)) | ($urandom_range(0, 1) ? 16'h1FF0 : 16'h0000);
      end else begin
        off = 16'($urandom_range(0, WORK_RAM_BYTES - 1));
      end
      if (off < (ADDR_OAM_BASE - ECHO_BASE) && $urandom_range(0, 3) == 0) begin
        r.address = ECHO_BASE + off;
      end else begin
        r.address = ADDR_WRAM_BASE + off;
      end
    end else if (pick < 55) begin
      case ($urandom_range(0, 7))
        0: port = PORT_JOYPAD;
        1: port = DIVIDER_SLOT;
        2: port = PORT_READ_ONLY;
        3: port = PORT_DMA;
        default: port = 8'($urandom);
      endcase
      r.address = ADDR_IO_BASE | 16'(port);
    end else if (pick < 70) begin
      if ($urandom_range(0, 1)) r.address = 16'($urandom_range(0, 16'h7FFF));
      else r.address = 16'($urandom_range(ADDR_CART2_BASE, ADDR_WRAM_BASE - 1));
    end else if (pick < 78) begin
      r.address = 16'($urandom_range(ADDR_VRAM_BASE, ADDR_CART2_BASE - 1));
    end else if (pick < 86) begin
      r.address = 16'($urandom_range(ADDR_OAM_BASE, ADDR_UNMAP_BASE - 1));
    end else if (pick < 92) begin
      r.address = 16'($urandom_range(ADDR_UNMAP_BASE, ADDR_IO_BASE - 1));
    end else begin
      r.address = 16'($urandom);
    end
    return r;
  endfunction

  // offer one request and log its expected response once accepted
  task automatic issue_request(input req_t r, input logic known, input rsp_t typed);
    rsp_t predicted;
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = decode_access(r);
    pending_responses.push_back(known ? typed : predicted);
  endtask

  task automatic hold_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // response checker
  always @(posedge clk) begin : response_check
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      responses_seen++;
      if (pending_responses.size() == 0) begin
        $error("response with no request pending");
        mismatch_count++;
      end else begin
        e = pending_responses.pop_front();
        check_field("read_data", 16'(e.read_data), 16'(out_rsp.read_data));
        check_field("target", 16'(e.target), 16'(out_rsp.target));
        check_field("forward_address", e.forward_address, out_rsp.forward_address);
        check_field("forward_write", 16'(e.forward_write), 16'(out_rsp.forward_write));
        check_field("forward_data", 16'(e.forward_data), 16'(out_rsp.forward_data));
        check_field("joypad_update", 16'(e.joypad_update), 16'(out_rsp.joypad_update));
        check_field("dma_start", 16'(e.dma_start), 16'(out_rsp.dma_start));
        check_field("dma_source", e.dma_source, out_rsp.dma_source);
        check_field("violation", 16'(e.violation), 16'(out_rsp.violation));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // response side ready, with one long hold-off to back up the pipe
  initial begin : response_ready
    int  hi;
    int  lo;
    logic backed_up;
    backed_up = 1'b0;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!backed_up && responses_seen >= BACKPRESSURE_AT) begin
        backed_up = 1'b1;
        out_ready <= 1'b0;
        repeat (BACKPRESSURE_LEN) @(posedge clk);
      end
      hi = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (hi) @(posedge clk);
      lo = idle_cycles();
      if (lo > 0) begin
        out_ready <= 1'b0;
        repeat (lo) @(posedge clk);
      end
    end
  end

  // reset, directed table, random requests, drain
  initial begin : request_source
    int   i;
    int   gap;
    req_t r;
    rsp_t idle_rsp;
    idle_rsp = '0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    for (i = 0; i < WORK_RAM_BYTES; i++) wram_image[i] = 8'h00;
    for (i = 0; i < IO_BYTES; i++) io_image[i] = 8'h00;

    // map edges and special ports
    directed_rows.push_back(known_row(KIND_READ, 16'hC000, 8'h00,
        rsp_of(8'h00, TGT_INTERNAL, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000, VIOL_NONE)));
    directed_rows.push_back(access_row(KIND_WRITE, 16'hC000, 8'hFF));
    directed_rows.push_back(access_row(KIND_READ, 16'hC000, 8'h00));
    directed_rows.push_back(access_row(KIND_WRITE, 16'hDFFF, 8'hA5));
    directed_rows.push_back(access_row(KIND_READ, 16'hFDFF, 8'h00));
    directed_rows.push_back(access_row(KIND_READ, 16'hE000, 8'h00));
    directed_rows.push_back(access_row(KIND_WRITE, 16'hE001, 8'h5A));
    directed_rows.push_back(access_row(KIND_READ, 16'hC001, 8'h00));
    directed_rows.push_back(access_row(KIND_WRITE, 16'h0000, 8'h00));
    directed_rows.push_back(known_row(KIND_WRITE, 16'h7FFF, 8'hFF,
        rsp_of(8'h00, TGT_CART, 16'h7FFF, 1'b1, 8'hFF, 1'b0, 1'b0, 16'h0000, VIOL_NONE)));
    directed_rows.push_back(access_row(KIND_WRITE, 16'hBFFF, 8'h81));
    directed_rows.push_back(access_row(KIND_WRITE, 16'h8000, 8'hFF));
    directed_rows.push_back(access_row(KIND_READ, 16'h9FFF, 8'h00));
    directed_rows.push_back(access_row(KIND_WRITE, 16'hFE00, 8'hFF));
    directed_rows.push_back(access_row(KIND_READ, 16'hFE9F, 8'h00));
    directed_rows.push_back(known_row(KIND_READ, 16'hFEA0, 8'h00,
        rsp_of(8'h00, TGT_UNMAPPED, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000,
               VIOL_UNMAPPED)));
    directed_rows.push_back(known_row(KIND_WRITE, 16'hFEFF, 8'hFF,
        rsp_of(8'h00, TGT_UNMAPPED, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000,
               VIOL_UNMAPPED)));
    directed_rows.push_back(known_row(KIND_WRITE, 16'hFF00, 8'hFF,
        rsp_of(8'h00, TGT_INTERNAL, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 16'h0000, VIOL_NONE)));
    directed_rows.push_back(access_row(KIND_READ, 16'hFF00, 8'h00));
    directed_rows.push_back(known_row(KIND_WRITE, 16'hFF44, 8'hFF,
        rsp_of(8'h00, TGT_INTERNAL, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000,
               VIOL_READ_ONLY)));
    directed_rows.push_back(access_row(KIND_READ, 16'hFF44, 8'h00));
    directed_rows.push_back(access_row(KIND_WRITE, 16'hFF04, 8'hAA));
    directed_rows.push_back(access_row(KIND_READ, 16'hFF04, 8'h00));
    directed_rows.push_back(known_row(KIND_WRITE, 16'hFF46, 8'hFF,
        rsp_of(8'h00, TGT_INTERNAL, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b1, 16'hFF00, VIOL_NONE)));
    directed_rows.push_back(access_row(KIND_READ, 16'hFF46, 8'h00));
    directed_rows.push_back(access_row(KIND_WRITE, 16'hFFFF, 8'hFF));
    directed_rows.push_back(access_row(KIND_READ, 16'hFFFF, 8'h00));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      issue_request(directed_rows[k].req, directed_rows[k].known, directed_rows[k].rsp);
      hold_sender(idle_cycles());
    end

    // random part, with stretches of back-to-back requests
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      r = random_request();
      issue_request(r, 1'b0, idle_rsp);
      gap = ((i / 64) % 3 == 1) ? 0 : idle_cycles();
      hold_sender(gap);
    end
    in_valid <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
